>>> rtl/vdt_pkg.sv
package vdt_pkg;

	// Number of table entries; one cell per entry.
	localparam int CAPACITY = 256;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Match bits are folded in groups before the final OR.
	localparam int GRP_SIZE = 16;
	localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [31:0] MAG_MASK     = 32'h7FFF_FFFF;
	localparam logic [31:0] EXP_ALL_ONES = 32'h7F80_0000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} pos_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic clear;
		logic insert;
	} cell_ctl_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b & MAG_MASK) > EXP_ALL_ONES;
	endfunction

	// Float equality: NaN never matches, and +0 matches -0.
	function automatic logic comp_eq(input logic [31:0] a, input logic [31:0] b);
		logic zero_pair;
		zero_pair = ((a & MAG_MASK) == 32'd0) && ((b & MAG_MASK) == 32'd0);
		return !is_nan(a) && !is_nan(b) && (zero_pair || (a == b));
	endfunction

	function automatic logic pos_eq(input pos_t a, input pos_t b);
		return comp_eq(a.x, b.x) && comp_eq(a.y, b.y) && comp_eq(a.z, b.z);
	endfunction

endpackage

>>> rtl/vdt_in_if.sv
interface vdt_in_if;
	logic        valid;
	logic        ready;
	logic        start_mesh;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;

	modport source (output valid, output start_mesh, output pos_x, output pos_y,
		output pos_z, input ready);
	modport sink (input valid, input start_mesh, input pos_x, input pos_y,
		input pos_z, output ready);
endinterface

>>> rtl/vdt_out_if.sv
interface vdt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] vertex_index;
	logic       is_new;
	logic       table_full;

	modport source (output valid, output vertex_index, output is_new,
		output table_full, input ready);
	modport sink (input valid, input vertex_index, input is_new,
		input table_full, output ready);
endinterface

>>> rtl/vdt_cell.sv
// One table entry. The cell fills only when its left neighbor is already
// filled, so the filled cells always form a prefix of the chain.
module vdt_cell
	import vdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  pos_t      key,
	input  logic      prev_valid,
	output logic      valid,
	output logic      match_s1
);

	pos_t entry_q;
	logic valid_q;
	logic wr_en;

	assign wr_en = ctl.insert && prev_valid && !valid_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (wr_en) begin
				valid_q <= 1'b1;
			end
			match_s1 <= valid_q && pos_eq(entry_q, key);
		end
	end

endmodule

>>> rtl/vertex_dedup_table.sv
// Channel  | Dir | Payload                                  | Meaning
// vertex   | in  | start_mesh, pos_x, pos_y, pos_z          | one vertex position request
// result   | out | vertex_index, is_new, table_full         | index assigned to that vertex
//
// Each request passes through accept, a compare in every cell, a registered
// fold of the match bits in groups, and a final fold that writes the result register.
// A new request is taken once the previous one has reached the result register,
// so the block never works on two requests at once.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result holds the final step until the result register frees up.
module vertex_dedup_table
	import vdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	vdt_in_if.sink      vertex,
	vdt_out_if.source   result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED,
		ST_FIN
	} state_t;

	state_t state_q;

	pos_t            key_q;
	logic [CNT_W-1:0] count_q;
	cell_ctl_t       ctl;

	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_match;

	logic [NUM_GRP-1:0]   grp_hit_d;
	logic [IDX_W-1:0]     grp_idx_d [NUM_GRP];
	logic [NUM_GRP-1:0]   grp_hit_s2;
	logic [IDX_W-1:0]     grp_idx_s2 [NUM_GRP];

	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic             full;
	logic             accept;
	logic             fin_go;

	logic       out_valid_q;
	logic [7:0] out_index_q;
	logic       out_new_q;
	logic       out_full_q;

	assign accept = vertex.valid && vertex.ready;
	assign vertex.ready = (state_q == ST_IDLE);

	// The table is full when the count has reached the number of cells.
	assign full = (count_q == CNT_W'(CAPACITY));

	// The final step proceeds only when the result register can take a value.
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	// A start flag clears every cell in the accept cycle, before the compare.
	assign ctl.clear  = accept && vertex.start_mesh;
	assign ctl.insert = fin_go && !hit && !full;

	// The chain of cells. Each cell hands its filled flag to its right neighbor,
	// which lets exactly the first empty cell take an insertion.
	for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
		logic prev_valid;
		if (c == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_link
			assign prev_valid = cell_valid[c-1];
		end
		vdt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key_q),
			.prev_valid (prev_valid),
			.valid      (cell_valid[c]),
			.match_s1   (cell_match[c])
		);
	end

	// Stored positions are distinct under float equality, so at most one cell
	// matches and the index can be formed by OR-ing the masked cell indices.
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_hit_d[g] = 1'b0;
			grp_idx_d[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if ((g * GRP_SIZE + j) < CAPACITY) begin
					if (cell_match[g * GRP_SIZE + j]) begin
						grp_hit_d[g] = 1'b1;
						grp_idx_d[g] = grp_idx_d[g] | IDX_W'(g * GRP_SIZE + j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_idx_s2[g] <= grp_idx_d[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_hit_s2 <= '0;
		end else begin
			grp_hit_s2 <= grp_hit_d;
		end
	end

	always_comb begin
		hit     = |grp_hit_s2;
		hit_idx = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			hit_idx = hit_idx | grp_idx_s2[g];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.x <= vertex.pos_x;
			key_q.y <= vertex.pos_y;
			key_q.z <= vertex.pos_z;
		end
	end

	// Sequencer, entry count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_new_q   <= 1'b0;
			out_full_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
						if (vertex.start_mesh) begin
							count_q <= '0;
						end
					end
				end
				ST_CMP: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (hit) begin
					out_index_q <= 8'(hit_idx);
					out_new_q   <= 1'b0;
					out_full_q  <= 1'b0;
				end else if (full) begin
					out_index_q <= '0;
					out_new_q   <= 1'b0;
					out_full_q  <= 1'b1;
				end else begin
					out_index_q <= 8'(count_q[IDX_W-1:0]);
					out_new_q   <= 1'b1;
					out_full_q  <= 1'b0;
					count_q     <= count_q + CNT_W'(1);
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.vertex_index = out_index_q;
	assign result.is_new       = out_new_q;
	assign result.table_full   = out_full_q;

`ifndef SYNTHESIS
	// Distinct stored positions mean no request ever matches two cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED) |-> ($countones(cell_match) <= 1))
		else $error("vertex matched more than one table entry");

	// The count never runs past the number of cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	// The filled cells must agree with the entry count in the final step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> ($countones(cell_valid) == int'(count_q)))
		else $error("filled cells disagree with entry count");

	// A start flag empties the table before the compare.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && vertex.start_mesh) |=> ((count_q == '0) && (cell_valid == '0)))
		else $error("table not cleared by start of mesh");
`endif

endmodule

>>> tb/vertex_dedup_checker.sv
`timescale 1ns / 100ps

module vertex_dedup_checker
	import vdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	vdt_in_if    vertex,
	vdt_out_if   result,
	output int   fail_count,
	output int   outstanding
);

	typedef struct packed {
		logic [7:0] index;
		logic       fresh;
		logic       full;
	} vertex_ref_t;

	pos_t        known_pos [CAPACITY];
	int unsigned known_cnt;
	vertex_ref_t index_q [$];
	int          errors;

	// Float equality on raw single patterns: a NaN matches nothing, and the two zeros match.
	function automatic logic same_comp(input logic [31:0] a, input logic [31:0] b);
		logic a_nan;
		logic b_nan;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (a_nan || b_nan)
			return 1'b0;
		if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
			return 1'b1;
		return a == b;
	endfunction

	// Looks a position up in the predicted table and inserts it when it is new.
	function automatic vertex_ref_t lookup_vertex(input logic start, input pos_t p);
		vertex_ref_t r;
		int          hit;
		hit = -1;
		if (start)
			known_cnt = 0;
		for (int i = 0; i < known_cnt; i++) begin
			if (hit < 0 && same_comp(known_pos[i].x, p.x) && same_comp(known_pos[i].y, p.y)
					&& same_comp(known_pos[i].z, p.z))
				hit = i;
		end
		if (hit >= 0) begin
			r.index = 8'(hit);
			r.fresh = 1'b0;
			r.full  = 1'b0;
		end else if (known_cnt >= CAPACITY) begin
			r.index = 8'd0;
			r.fresh = 1'b0;
			r.full  = 1'b1;
		end else begin
			known_pos[known_cnt] = p;
			r.index = 8'(known_cnt);
			r.fresh = 1'b1;
			r.full  = 1'b0;
			known_cnt++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_ref_t exp_r;
		pos_t        p;
		if (!arst_n) begin
			known_cnt = 0;
			index_q.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (index_q.size() == 0) begin
					$display("%0t: result with no request waiting: index %0d new %0b full %0b",
						$time, result.vertex_index, result.is_new, result.table_full);
					errors++;
				end else begin
					exp_r = index_q.pop_front();
					if (result.vertex_index !== exp_r.index) begin
						$display("%0t: vertex_index mismatch: expected %0d, actual %0d",
							$time, exp_r.index, result.vertex_index);
						errors++;
					end
					if (result.is_new !== exp_r.fresh) begin
						$display("%0t: is_new mismatch: expected %0b, actual %0b",
							$time, exp_r.fresh, result.is_new);
						errors++;
					end
					if (result.table_full !== exp_r.full) begin
						$display("%0t: table_full mismatch: expected %0b, actual %0b",
							$time, exp_r.full, result.table_full);
						errors++;
					end
				end
			end
			if (vertex.valid && vertex.ready) begin
				p.x = vertex.pos_x;
				p.y = vertex.pos_y;
				p.z = vertex.pos_z;
				exp_r = lookup_vertex(vertex.start_mesh, p);
				index_q = {index_q, exp_r};
			end
			fail_count <= errors;
			outstanding <= index_q.size();
		end
	end

endmodule

>>> tb/tb_vertex_dedup_table.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the vertex deduplication table. The checker beside the block
// predicts every result and counts failures; this module only makes requests, drives the
// result ready line, and decides the outcome once the block has drained.
module tb_vertex_dedup_table;
	import vdt_pkg::*;

	localparam int RAND_ITEMS  = 1280;
	localparam int CYCLE_LIMIT = 400000;
	// Results after which the receiver holds off for a long stretch.
	localparam int HOLD_AT_A   = 50;
	localparam int HOLD_AT_B   = 600;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   cycles = 0;

	// Sender pacing: stretches with no gaps and stretches of random gaps, drawn at random.
	logic tx_calm = 1'b0;
	int   tx_left = 0;

	vdt_in_if  vertex_ch ();
	vdt_out_if result_ch ();

	vertex_dedup_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex_ch),
		.result (result_ch)
	);

	vertex_dedup_checker vtx_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex      (vertex_ch),
		.result      (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// A hung block ends the run here rather than in the drain loop below.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One component: half the draws are fixed values that collide often, so partial matches are
	// common (both zeros, plus and minus one, infinity), the rest a random NaN or a random pattern.
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h3F80_0000;
			3: return 32'hBF80_0000;
			4: return 32'h7F80_0000;
			5: return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
			default: return $urandom();
		endcase
	endfunction

	// A repeated position may carry the other sign on any zero component; it must still hit.
	function automatic pos_t sign_jitter(input pos_t p);
		if (p.x[30:0] == 31'd0 && $urandom_range(0, 1) == 1)
			p.x[31] = ~p.x[31];
		if (p.y[30:0] == 31'd0 && $urandom_range(0, 1) == 1)
			p.y[31] = ~p.y[31];
		if (p.z[30:0] == 31'd0 && $urandom_range(0, 1) == 1)
			p.z[31] = ~p.z[31];
		return p;
	endfunction

	// Offers one request after a drawn gap and returns at the edge that accepts it.
	// Valid is lowered only when a gap follows, so back-to-back requests keep it high.
	task automatic send_vertex(input logic st, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		int gap;
		if (tx_left == 0) begin
			tx_calm = ($urandom_range(0, 2) == 0);
			tx_left = $urandom_range(20, 80);
		end
		tx_left--;
		gap = tx_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			vertex_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_ch.valid      <= 1'b1;
		vertex_ch.start_mesh <= st;
		vertex_ch.pos_x      <= x;
		vertex_ch.pos_y      <= y;
		vertex_ch.pos_z      <= z;
		do @(posedge clk); while (!vertex_ch.ready);
	endtask

	// Receiver: random stalls with calm stretches, and two long hold-offs during which the
	// sender keeps offering requests, so the block fills and pushes back on its input.
	initial begin
		int   got;
		int   stall;
		logic rx_calm;
		got = 0;
		rx_calm = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (got % 40 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (got == HOLD_AT_A || got == HOLD_AT_B)
				stall = HOLD_CYCLES;
			else
				stall = rx_calm ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got++;
		end
	end

	initial begin
		int   sent;
		int   mesh_no;
		int   mesh_len;
		logic big;
		logic st;
		pos_t p;
		pos_t hist [$];

		arst_n               <= 1'b0;
		vertex_ch.valid      <= 1'b0;
		vertex_ch.start_mesh <= 1'b0;
		vertex_ch.pos_x      <= 32'd0;
		vertex_ch.pos_y      <= 32'd0;
		vertex_ch.pos_z      <= 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests. The zero vertex and its negative-zero spellings must all hit.
		send_vertex(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vertex(1'b0, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
		// An all-ones vertex is a NaN in every component, so it is new every time.
		send_vertex(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_vertex(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Infinities and the largest finite value match themselves.
		send_vertex(1'b0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF);
		send_vertex(1'b0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF);
		// A NaN in a single component is enough to make the vertex new.
		send_vertex(1'b0, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(1'b0, 32'h0000_0000, 32'h7F80_0001, 32'h0000_0000);
		send_vertex(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		// Signed denormals are not zeros: these two differ from each other.
		send_vertex(1'b0, 32'h0000_0001, 32'h8000_0001, 32'h0000_0000);
		send_vertex(1'b0, 32'h8000_0001, 32'h0000_0001, 32'h0000_0000);
		send_vertex(1'b0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(1'b0, 32'h3F80_0000, 32'h0000_0000, 32'h8000_0000);
		// A new mesh empties the table; an old position gets index zero again.
		send_vertex(1'b1, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(1'b1, 32'hFF7F_FFFF, 32'h0000_0000, 32'h7F7F_FFFF);
		send_vertex(1'b1, 32'hFF7F_FFFF, 32'h0000_0000, 32'h7F7F_FFFF);
		send_vertex(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);

		// Random meshes. Each one opens with start_mesh and mixes fresh positions with
		// repeats. Two meshes are large enough to overflow the table, so the full case is
		// hit together with repeats of stored and of rejected positions after it.
		sent = 0;
		mesh_no = 0;
		while (sent < RAND_ITEMS) begin
			big = (mesh_no == 1 || mesh_no == 9);
			mesh_len = big ? $urandom_range(300, 340) : $urandom_range(1, 60);
			hist.delete();
			for (int k = 0; k < mesh_len && sent < RAND_ITEMS; k++) begin
				st = (k == 0);
				if (k > 0 && $urandom_range(0, 19) == 0) begin
					// Noise: a raw random request, occasionally breaking the mesh early.
					st = big ? 1'b0 : 1'($urandom_range(0, 1));
					send_vertex(st, $urandom(), $urandom(), $urandom());
				end else begin
					if (k > 0 && hist.size() > 0 && $urandom_range(0, 99) < (big ? 10 : 45))
						p = sign_jitter(hist[$urandom_range(0, hist.size() - 1)]);
					else if (big && $urandom_range(0, 9) != 0)
						p = {$urandom(), $urandom(), $urandom()};
					else
						p = {pick_comp(), pick_comp(), pick_comp()};
					hist = {hist, p};
					send_vertex(st, p.x, p.y, p.z);
				end
				sent++;
			end
			mesh_no++;
		end
		vertex_ch.valid <= 1'b0;

		// Drain: every predicted result must arrive, then a further wait for stray outputs.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/vdt_pkg.sv
rtl/vdt_in_if.sv
rtl/vdt_out_if.sv
rtl/vdt_cell.sv
rtl/vertex_dedup_table.sv
tb/vertex_dedup_checker.sv
tb/tb_vertex_dedup_table.sv
